// ===== design/eds_pkg.sv =====
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types and constants of the event deadline scheduler: request and
// response payloads, operation codes, interrupt status constants and the
// order in which a test visits the event slots.
// ----------------------------------------------------------------------------
package eds_pkg;

   typedef enum logic {
      OP_SCHEDULE = 1'b0,
      OP_TEST     = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        now_cycle;
      logic [4:0]         event_id;
      logic signed [31:0] event_delay;
      logic [31:0]        counter_start;
      logic signed [31:0] counter_delay;
      logic [31:0]        irq_control;
      logic [31:0]        irq_status;
      logic [31:0]        irq_mask;
      logic [31:0]        cpu_status;
   } req_type;

   typedef struct packed {
      logic [31:0] fired_mask;
      logic        counter_due;
      logic        take_interrupt;
      logic [31:0] next_check_cycle;
   } rsp_type;

   localparam logic [31:0] STATUS_IRQ_MASK   = 32'h0000_FE01;
   localparam logic [31:0] STATUS_IRQ_MIN    = 32'h0000_0401;
   localparam logic [31:0] NEXT_CHECK_RESET  = 32'd8;

   // Number of slots visited by a test, and the index of the last one.
   localparam int          WALK_LEN  = 10;
   localparam logic [3:0]  WALK_LAST = 4'(WALK_LEN - 1);

   // Slot visited at each step of a test.
   function automatic logic [4:0] walk_slot(input logic [3:0] idx);
      logic [4:0] slot;
      unique case (idx)
         4'd0:    slot = 5'd9;
         4'd1:    slot = 5'd10;
         4'd2:    slot = 5'd16;
         4'd3:    slot = 5'd19;
         4'd4:    slot = 5'd11;
         4'd5:    slot = 5'd12;
         4'd6:    slot = 5'd17;
         4'd7:    slot = 5'd18;
         4'd8:    slot = 5'd20;
         4'd9:    slot = 5'd21;
         default: slot = 5'd0;
      endcase
      return slot;
   endfunction

endpackage

// ===== design/eds_ram.sv =====
// ----------------------------------------------------------------------------
// eds_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module eds_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/event_deadline_scheduler.sv =====
// ----------------------------------------------------------------------------
// event_deadline_scheduler
// Per-slot deadline scheduler for I/O processor events.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req_payload) carries schedule and
// test operations; the response channel (rsp_valid, rsp_ready, rsp_payload)
// returns exactly one result per request, in order.
// A schedule arms a slot, stores its start cycle and delay in the slot RAM and
// pulls the next-check cycle earlier when needed. A test checks the root
// counter and the interrupt condition, then walks ten slots through the
// single RAM read port, one slot a cycle, firing those whose deadline has
// passed. A schedule goes through S_SCHED and S_DONE, a test through S_INIT,
// S_WALK and S_DONE, before the result is registered; a new request is taken
// only once the block is back in S_IDLE. The ten-step walk over the RAM read
// port makes a test the longer operation.
// The response is registered, so a new request is accepted while a result
// still waits; the block only holds a finished item when the previous result
// has not yet been transferred.
// Reset clears all pending slots and sets the next-check cycle to 8. The slot
// RAM is not cleared: slot data is used only while its pending bit is set.
// ----------------------------------------------------------------------------
module event_deadline_scheduler #(
   parameter int EVENT_SLOTS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  eds_pkg::req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output eds_pkg::rsp_type rsp_payload
);

   localparam int ADDR_W = $clog2(EVENT_SLOTS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCHED = 5'b00010,
      S_INIT  = 5'b00100,
      S_WALK  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   eds_pkg::req_type        req_ff;
   logic [EVENT_SLOTS-1:0]  pending_ff, pending_in;
   logic [31:0]             next_check_ff, next_check_in;
   logic [31:0]             fired_ff, fired_in;
   logic                    cdue_ff, cdue_in;
   logic                    irq_ff, irq_in;
   logic [3:0]              walk_idx_ff, walk_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   eds_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [63:0]             ram_rd_data;

   logic                    req_xfer;
   logic                    id_in_range;
   logic [4:0]              cur_slot;
   logic [31:0]             slot_start;
   logic signed [31:0]      slot_delay;
   logic signed [31:0]      since_start;
   logic signed [31:0]      check_gap;
   logic signed [31:0]      sched_gap;
   logic signed [31:0]      counter_since;

   eds_ram #(
      .WIDTH(64),
      .DEPTH(EVENT_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_ff.now_cycle, req_ff.event_delay}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign req_xfer    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign id_in_range = ({1'b0, req_ff.event_id} < 6'(EVENT_SLOTS));
   assign ram_wr_en   = (state_ff == S_SCHED) && id_in_range;
   assign ram_wr_addr = ADDR_W'(req_ff.event_id);

   // The RAM read for a step is issued in the cycle before the step itself.
   assign cur_slot    = eds_pkg::walk_slot(walk_idx_ff);
   assign slot_start  = ram_rd_data[63:32];
   assign slot_delay  = $signed(ram_rd_data[31:0]);

   // Wrapping differences, read as signed values.
   assign since_start   = $signed(req_ff.now_cycle - slot_start);
   assign check_gap     = $signed(next_check_ff - slot_start);
   assign sched_gap     = $signed(next_check_ff - req_ff.now_cycle);
   assign counter_since = $signed(req_ff.now_cycle - req_ff.counter_start);

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      next_check_in = next_check_ff;
      fired_in      = fired_ff;
      cdue_in       = cdue_ff;
      irq_in        = irq_ff;
      walk_idx_in   = walk_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ram_rd_addr   = ADDR_W'(eds_pkg::walk_slot(walk_idx_ff + 4'd1));

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               fired_in    = '0;
               cdue_in     = 1'b0;
               irq_in      = 1'b0;
               walk_idx_in = '0;
               if (req_payload.op == eds_pkg::OP_TEST) begin
                  state_in = S_INIT;
               end else begin
                  state_in = S_SCHED;
               end
            end
         end
         S_SCHED: begin
            if (id_in_range) begin
               pending_in[ADDR_W'(req_ff.event_id)] = 1'b1;
               if (sched_gap > req_ff.event_delay) begin
                  next_check_in = req_ff.now_cycle + req_ff.event_delay;
               end
            end
            state_in = S_DONE;
         end
         S_INIT: begin
            ram_rd_addr   = ADDR_W'(eds_pkg::walk_slot('0));
            cdue_in       = (counter_since >= req_ff.counter_delay);
            next_check_in = req_ff.counter_start + req_ff.counter_delay;
            irq_in        = (req_ff.irq_control != '0)
                         && ((req_ff.irq_status & req_ff.irq_mask) != '0)
                         && ((req_ff.cpu_status & eds_pkg::STATUS_IRQ_MASK)
                             >= eds_pkg::STATUS_IRQ_MIN);
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (pending_ff[ADDR_W'(cur_slot)]) begin
               if (since_start >= slot_delay) begin
                  fired_in[cur_slot]               = 1'b1;
                  pending_in[ADDR_W'(cur_slot)]    = 1'b0;
               end else if (check_gap > slot_delay) begin
                  next_check_in = slot_start + slot_delay;
               end
            end
            walk_idx_in = walk_idx_ff + 4'd1;
            if (walk_idx_ff == eds_pkg::WALK_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait only while the previous result has not been transferred.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_in.fired_mask       = fired_ff;
               rsp_in.counter_due      = cdue_ff;
               rsp_in.take_interrupt   = irq_ff;
               rsp_in.next_check_cycle = next_check_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pending_ff    <= '0;
         next_check_ff <= eds_pkg::NEXT_CHECK_RESET;
         rsp_valid_ff  <= 1'b0;
         walk_idx_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         next_check_ff <= next_check_in;
         rsp_valid_ff  <= rsp_valid_in;
         walk_idx_ff   <= walk_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_payload;
      end
      fired_ff <= fired_in;
      cdue_ff  <= cdue_in;
      irq_ff   <= irq_in;
      rsp_ff   <= rsp_in;
   end

endmodule
